// ===== sv/mbrtu_pkg.sv =====
package mbrtu_pkg;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_COLLECT = 2'd1,
        PH_DROP    = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ILL_FUNC  = 3'd1,
        ST_ILL_QTY   = 3'd2,
        ST_CRC_ERR   = 3'd3,
        ST_SHORT     = 3'd4
    } t_status;

    typedef struct packed {
        t_status    status;
        logic [7:0] length;
    } t_hdr_res;

    localparam logic [7:0]  SLAVE_ADDR_RST = 8'h01;
    localparam logic [7:0]  FC_BASIC_FIRST = 8'h01;
    localparam logic [7:0]  FC_BASIC_LAST  = 8'h06;
    localparam logic [7:0]  FC_WR_COILS    = 8'h0F;
    localparam logic [7:0]  FC_WR_REGS     = 8'h10;
    localparam logic [15:0] MAX_COILS      = 16'h07B0;
    localparam logic [15:0] MAX_REGS       = 16'h007B;
    localparam logic [7:0]  HDR_LEN        = 8'd8;
    localparam logic [7:0]  HDR_LAST_POS   = 8'd7;
    localparam logic [7:0]  TRAILER_LEN    = 8'd9;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;

    function automatic logic is_multi(input logic [7:0] fc);
        return (fc == FC_WR_COILS) || (fc == FC_WR_REGS);
    endfunction

    // One byte of the reflected Modbus CRC-16.
    function automatic logic [15:0] crc_absorb(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/mbrtu_ifs.sv =====
interface mbrtu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       gap;

    modport source (output valid, output rx_byte, output gap, input ready);
    modport sink   (input valid, input rx_byte, input gap, output ready);
endinterface

interface mbrtu_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic [7:0]  byte_count;
    logic [7:0]  frame_length;

    modport source (output valid, output status, output function_code, output start_address,
                    output quantity, output byte_count, output frame_length, input ready);
    modport sink   (input valid, input status, input function_code, input start_address,
                    input quantity, input byte_count, input frame_length, output ready);
endinterface

// ===== sv/mbrtu_hdr_check.sv =====
module mbrtu_hdr_check (
    input  logic [7:0]              i_function,
    input  logic [15:0]             i_quantity,
    input  logic [7:0]              i_count,
    output mbrtu_pkg::t_hdr_res     o_res
);

    logic [16:0] coil_sum;
    logic [13:0] coil_bytes;
    logic [16:0] reg_bytes;
    logic        qty_nonzero;

    assign coil_sum    = {1'b0, i_quantity} + 17'd7;
    assign coil_bytes  = coil_sum[16:3];
    assign reg_bytes   = {i_quantity, 1'b0};
    assign qty_nonzero = (i_quantity != 16'd0);

    always_comb begin
        o_res.status = mbrtu_pkg::ST_ILL_FUNC;
        o_res.length = 8'd0;
        case (i_function) inside
            [mbrtu_pkg::FC_BASIC_FIRST:mbrtu_pkg::FC_BASIC_LAST]: begin
                o_res.status = mbrtu_pkg::ST_OK;
                o_res.length = mbrtu_pkg::HDR_LEN;
            end
            mbrtu_pkg::FC_WR_COILS: begin
                if (qty_nonzero && (i_quantity <= mbrtu_pkg::MAX_COILS)
                        && (coil_bytes == {6'd0, i_count})) begin
                    o_res.status = mbrtu_pkg::ST_OK;
                    o_res.length = coil_bytes[7:0] + mbrtu_pkg::TRAILER_LEN;
                end else begin
                    o_res.status = mbrtu_pkg::ST_ILL_QTY;
                end
            end
            mbrtu_pkg::FC_WR_REGS: begin
                if (qty_nonzero && (i_quantity <= mbrtu_pkg::MAX_REGS)
                        && (reg_bytes == {9'd0, i_count})) begin
                    o_res.status = mbrtu_pkg::ST_OK;
                    o_res.length = reg_bytes[7:0] + mbrtu_pkg::TRAILER_LEN;
                end else begin
                    o_res.status = mbrtu_pkg::ST_ILL_QTY;
                end
            end
            default: begin
                o_res.status = mbrtu_pkg::ST_ILL_FUNC;
                o_res.length = 8'd0;
            end
        endcase
    end

endmodule

// ===== sv/modbus_rtu_request_frame_checker_top.sv =====
// A registered result appears on the output in the cycle after the transfer of the byte or gap
// that completes or ends the frame.
// Throughput: one input item per cycle; the parser state and the CRC step are combinational.
// A result that is held back stalls the input until the cycle in which it is taken.
// Reset (synchronous, active low): hunting for the address, slave address 1, output empty.
module modbus_rtu_request_frame_checker_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    mbrtu_in_if.sink           i_in,
    mbrtu_out_if.source        o_out
);

    mbrtu_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_slave_addr;
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_needed, n_needed;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_tail, n_tail;
    logic [7:0]  r_function, n_function;
    logic [15:0] r_start, n_start;
    logic [15:0] r_quantity, n_quantity;
    logic [7:0]  r_count, n_count;

    logic        r_out_valid;
    logic [2:0]  r_status;
    logic [7:0]  r_out_function;
    logic [15:0] r_out_start;
    logic [15:0] r_out_quantity;
    logic [7:0]  r_out_count;
    logic [7:0]  r_out_length;

    logic                 accept;
    logic                 res_valid;
    mbrtu_pkg::t_status   res_status;
    logic [7:0]           res_length;
    mbrtu_pkg::t_hdr_res  hdr;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // Function, quantity and count are all settled before the eighth byte arrives.
    mbrtu_hdr_check u_hdr_check (
        .i_function (r_function),
        .i_quantity (r_quantity),
        .i_count    (r_count),
        .o_res      (hdr)
    );

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_needed   = r_needed;
        n_crc      = r_crc;
        n_tail     = r_tail;
        n_function = r_function;
        n_start    = r_start;
        n_quantity = r_quantity;
        n_count    = r_count;
        res_valid  = 1'b0;
        res_status = mbrtu_pkg::ST_OK;
        res_length = 8'd0;
        if (accept) begin
            unique case (r_phase)
                mbrtu_pkg::PH_DROP: begin
                    if (i_in.gap) begin
                        n_phase = mbrtu_pkg::PH_HUNT;
                    end
                end
                mbrtu_pkg::PH_COLLECT: begin
                    if (i_in.gap) begin
                        n_phase    = mbrtu_pkg::PH_HUNT;
                        res_valid  = 1'b1;
                        res_status = mbrtu_pkg::ST_SHORT;
                        res_length = r_needed;
                    end else begin
                        // The last two bytes stay out of the CRC until more bytes follow.
                        if (r_pos >= 8'd2) begin
                            n_crc = mbrtu_pkg::crc_absorb(r_crc, r_tail[15:8]);
                        end
                        n_tail = {r_tail[7:0], i_in.rx_byte};
                        case (r_pos)
                            8'd1: n_function = i_in.rx_byte;
                            8'd2: n_start[15:8] = i_in.rx_byte;
                            8'd3: n_start[7:0] = i_in.rx_byte;
                            8'd4: n_quantity[15:8] = i_in.rx_byte;
                            8'd5: n_quantity[7:0] = i_in.rx_byte;
                            8'd6: n_count = i_in.rx_byte;
                            default: ;
                        endcase
                        n_pos = r_pos + 8'd1;
                        if ((r_pos == mbrtu_pkg::HDR_LAST_POS)
                                && (hdr.status != mbrtu_pkg::ST_OK)) begin
                            n_phase    = mbrtu_pkg::PH_DROP;
                            res_valid  = 1'b1;
                            res_status = hdr.status;
                            res_length = 8'd0;
                        end else begin
                            if (r_pos == mbrtu_pkg::HDR_LAST_POS) begin
                                n_needed = hdr.length;
                            end
                            if ((n_pos >= mbrtu_pkg::HDR_LEN) && (n_pos >= n_needed)) begin
                                res_valid  = 1'b1;
                                res_length = n_needed;
                                if ({n_tail[7:0], n_tail[15:8]} != n_crc) begin
                                    n_phase    = mbrtu_pkg::PH_DROP;
                                    res_status = mbrtu_pkg::ST_CRC_ERR;
                                end else begin
                                    n_phase    = mbrtu_pkg::PH_HUNT;
                                    res_status = mbrtu_pkg::ST_OK;
                                end
                            end
                        end
                    end
                end
                default: begin
                    n_phase = mbrtu_pkg::PH_HUNT;
                    if (!i_in.gap && (i_in.rx_byte == r_slave_addr)) begin
                        n_phase    = mbrtu_pkg::PH_COLLECT;
                        n_pos      = 8'd1;
                        n_needed   = mbrtu_pkg::HDR_LEN;
                        n_crc      = mbrtu_pkg::CRC_INIT;
                        n_tail     = {8'h00, i_in.rx_byte};
                        n_function = 8'd0;
                        n_start    = 16'd0;
                        n_quantity = 16'd0;
                        n_count    = 8'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= mbrtu_pkg::PH_HUNT;
            r_slave_addr <= mbrtu_pkg::SLAVE_ADDR_RST;
            r_pos        <= 8'd0;
            r_needed     <= mbrtu_pkg::HDR_LEN;
            r_crc        <= mbrtu_pkg::CRC_INIT;
            r_tail       <= 16'd0;
            r_function   <= 8'd0;
            r_start      <= 16'd0;
            r_quantity   <= 16'd0;
            r_count      <= 8'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_needed   <= n_needed;
            r_crc      <= n_crc;
            r_tail     <= n_tail;
            r_function <= n_function;
            r_start    <= n_start;
            r_quantity <= n_quantity;
            r_count    <= n_count;
            if (i_cfg_wr_en) begin
                r_slave_addr <= i_cfg_wr_data;
            end
            if (accept && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res_valid) begin
            r_status       <= res_status;
            r_out_function <= n_function;
            r_out_start    <= n_start;
            r_out_quantity <= n_quantity;
            r_out_count    <= mbrtu_pkg::is_multi(n_function) ? n_count : 8'd0;
            r_out_length   <= res_length;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.function_code = r_out_function;
    assign o_out.start_address = r_out_start;
    assign o_out.quantity      = r_out_quantity;
    assign o_out.byte_count    = r_out_count;
    assign o_out.frame_length  = r_out_length;

endmodule

// ===== sim/mbrtu_frame_checker.sv =====
`timescale 1ns / 100ps

module mbrtu_frame_checker
    import mbrtu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    mbrtu_in_if  in_ch,
    mbrtu_out_if out_ch,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_in_count,
    output int   o_checked,
    output int   o_good
);

    typedef struct packed {
        t_status     status;
        logic [7:0]  fc;
        logic [15:0] start;
        logic [15:0] qty;
        logic [7:0]  cnt;
        logic [7:0]  len;
    } t_frame_res;

    // Shadow copy of the parser state.
    logic [7:0]  addr_cfg;
    t_phase      parse_ph;
    logic [7:0]  fr_pos;
    logic [7:0]  fr_need;
    logic [15:0] fr_crc;
    logic [15:0] fr_tail;
    logic [7:0]  fr_fc;
    logic [15:0] fr_start;
    logic [15:0] fr_qty;
    logic [7:0]  fr_cnt;

    t_frame_res pending_frames[$];

    function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8) begin
            c = {1'b0, c[15:1]} ^ (c[0] ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic void clear_frame();
        fr_pos   = 8'd0;
        fr_need  = HDR_LEN;
        fr_crc   = CRC_INIT;
        fr_tail  = 16'h0000;
        fr_fc    = 8'h00;
        fr_start = 16'h0000;
        fr_qty   = 16'h0000;
        fr_cnt   = 8'h00;
    endfunction

    function automatic t_frame_res make_result(input t_status st, input logic [7:0] len);
        t_frame_res r;
        r.status = st;
        r.fc     = fr_fc;
        r.start  = fr_start;
        r.qty    = fr_qty;
        r.cnt    = (fr_fc == FC_WR_COILS || fr_fc == FC_WR_REGS) ? fr_cnt : 8'h00;
        r.len    = len;
        return r;
    endfunction

    // Checks function, quantity and byte count once the eighth byte is in; sets the frame length.
    function automatic t_status header_verdict();
        int unsigned n;
        int unsigned c;
        n = 32'(fr_qty);
        if (fr_fc >= FC_BASIC_FIRST && fr_fc <= FC_BASIC_LAST) begin
            fr_need = HDR_LEN;
            return ST_OK;
        end
        if (fr_fc == FC_WR_COILS) begin
            c = (n + 32'd7) / 32'd8;
            if (n < 32'd1 || n > 32'(MAX_COILS) || c != 32'(fr_cnt)) return ST_ILL_QTY;
            fr_need = 8'(c + 32'(TRAILER_LEN));
            return ST_OK;
        end
        if (fr_fc == FC_WR_REGS) begin
            c = 32'd2 * n;
            if (n < 32'd1 || n > 32'(MAX_REGS) || c != 32'(fr_cnt)) return ST_ILL_QTY;
            fr_need = 8'(c + 32'(TRAILER_LEN));
            return ST_OK;
        end
        return ST_ILL_FUNC;
    endfunction

    // Advances the shadow parser by one transfer; returns 1 when a result is due.
    function automatic bit frame_outcome(input logic [7:0] b, input logic g,
                                         output t_frame_res res);
        logic [7:0]  p;
        t_status     st;
        logic [15:0] sent_crc;
        res = '0;
        if (parse_ph == PH_DROP) begin
            if (g) parse_ph = PH_HUNT;
            return 1'b0;
        end
        if (parse_ph != PH_COLLECT) begin
            parse_ph = PH_HUNT;
            if (g || b != addr_cfg) return 1'b0;
            clear_frame();
            fr_tail  = {8'h00, b};
            fr_pos   = 8'd1;
            parse_ph = PH_COLLECT;
            return 1'b0;
        end
        if (g) begin
            parse_ph = PH_HUNT;
            res = make_result(ST_SHORT, fr_need);
            return 1'b1;
        end

        // The CRC runs two bytes behind, so the trailer never enters it.
        p = fr_pos;
        if (p >= 8'd2) fr_crc = crc16_modbus_byte(fr_crc, fr_tail[15:8]);
        fr_tail = {fr_tail[7:0], b};
        case (p)
            8'd1: fr_fc = b;
            8'd2: fr_start[15:8] = b;
            8'd3: fr_start[7:0] = b;
            8'd4: fr_qty[15:8] = b;
            8'd5: fr_qty[7:0] = b;
            8'd6: fr_cnt = b;
            default: ;
        endcase
        fr_pos = p + 8'd1;

        if (p == HDR_LAST_POS) begin
            st = header_verdict();
            if (st != ST_OK) begin
                parse_ph = PH_DROP;
                res = make_result(st, 8'd0);
                return 1'b1;
            end
        end
        if (fr_pos >= HDR_LEN && fr_pos >= fr_need) begin
            sent_crc = {fr_tail[7:0], fr_tail[15:8]};
            if (sent_crc != fr_crc) begin
                parse_ph = PH_DROP;
                res = make_result(ST_CRC_ERR, fr_need);
            end else begin
                parse_ph = PH_HUNT;
                res = make_result(ST_OK, fr_need);
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void check_field(input string label, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", label, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_frame_res want;
        t_frame_res head;
        if (!i_rst_n) begin
            addr_cfg     = SLAVE_ADDR_RST;
            parse_ph     = PH_HUNT;
            clear_frame();
            o_fail_count = 0;
            o_in_count   = 0;
            o_checked    = 0;
            o_good       = 0;
        end else begin
            if (i_cfg_wr_en) addr_cfg = i_cfg_wr_data;
            if (in_ch.valid && in_ch.ready) begin
                o_in_count++;
                if (frame_outcome(in_ch.rx_byte, in_ch.gap, want)) pending_frames.push_back(want);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (pending_frames.size() == 0) begin
                    $error("result transfer with no frame outcome pending (status %0d)",
                           out_ch.status);
                    o_fail_count++;
                end else begin
                    head = pending_frames.pop_front();
                    check_field("status", 16'(head.status), 16'(out_ch.status));
                    check_field("function_code", 16'(head.fc), 16'(out_ch.function_code));
                    check_field("start_address", head.start, out_ch.start_address);
                    check_field("quantity", head.qty, out_ch.quantity);
                    check_field("byte_count", 16'(head.cnt), 16'(out_ch.byte_count));
                    check_field("frame_length", 16'(head.len), 16'(out_ch.frame_length));
                    o_checked++;
                    if (head.status == ST_OK) o_good++;
                end
            end
        end
        o_pending = pending_frames.size();
    end

endmodule

// ===== sim/tb_modbus_rtu_request_frame_checker_top.sv =====
`timescale 1ns / 100ps

module tb_modbus_rtu_request_frame_checker_top;
    import mbrtu_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_CHUNK = 25;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [7:0] i_cfg_wr_data;

    mbrtu_in_if  in_ch();
    mbrtu_out_if out_ch();

    int fail_count;
    int pending;
    int in_count;
    int checked;
    int good_count;

    logic [7:0] slave_addr;
    logic [7:0] frame_q[$];
    bit         steady;
    bit         hold_out;
    int         items_sent;
    int         cycles;

    modbus_rtu_request_frame_checker_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    mbrtu_frame_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_in_count    (in_count),
        .o_checked     (checked),
        .o_good        (good_count)
    );

    initial i_clk = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // Result side: mostly ready, short and occasional long stalls, free-running bursts,
    // and one long hold-off on request from the stimulus.
    initial begin : result_ready
        int r;
        int free_run;
        free_run = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_out) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_out = 1'b0;
                out_ch.ready <= 1'b1;
            end else if (free_run > 0) begin
                free_run--;
                out_ch.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    out_ch.ready <= 1'b0;
                    repeat ($urandom_range(20, 60)) @(negedge i_clk);
                    out_ch.ready <= 1'b1;
                end else if (r < 6) begin
                    free_run = $urandom_range(30, 120);
                    out_ch.ready <= 1'b1;
                end else begin
                    out_ch.ready <= (r >= 30);
                end
            end
        end
    end

    function automatic int sender_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 99) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // One input transfer; returns at the rising edge that accepts it.
    task automatic put(input logic [7:0] b, input logic g);
        int idle;
        idle = sender_gap();
        @(negedge i_clk);
        if (idle > 0) begin
            in_ch.valid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= b;
        in_ch.gap     <= g;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_slave(input logic [7:0] v);
        put(8'($urandom_range(0, 255)), 1'b1);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        slave_addr = v;
    endtask

    // Sends a request frame; a nonzero cut sends at most that many bytes followed by a gap.
    task automatic send_frame(input logic [7:0] fc, input logic [15:0] ad,
                              input logic [15:0] qt, input logic [7:0] cnt,
                              input bit bad_crc, input int cut);
        logic [15:0] crc;
        int n;
        frame_q = {};
        frame_q.push_back(slave_addr);
        frame_q.push_back(fc);
        frame_q.push_back(ad[15:8]);
        frame_q.push_back(ad[7:0]);
        frame_q.push_back(qt[15:8]);
        frame_q.push_back(qt[7:0]);
        if (fc == FC_WR_COILS || fc == FC_WR_REGS) begin
            frame_q.push_back(cnt);
            repeat (cnt) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        crc = CRC_INIT;
        foreach (frame_q[i]) crc = crc_absorb(crc, frame_q[i]);
        if (bad_crc) crc ^= 16'h0001 << $urandom_range(0, 15);
        frame_q.push_back(crc[7:0]);
        frame_q.push_back(crc[15:8]);
        n = (cut > 0 && cut < frame_q.size()) ? cut : frame_q.size();
        for (int i = 0; i < n; i++) put(frame_q[i], 1'b0);
        if (cut > 0) put(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Mostly small write-multiple requests; now and then the full quantity range.
    task automatic pick_good(output logic [7:0] fc, output logic [15:0] ad,
                             output logic [15:0] qt, output logic [7:0] cnt);
        int k;
        k = $urandom_range(0, 2);
        ad = 16'($urandom_range(0, 16'hFFFF));
        if (k == 0) begin
            fc  = 8'($urandom_range(FC_BASIC_FIRST, FC_BASIC_LAST));
            qt  = 16'($urandom_range(0, 16'hFFFF));
            cnt = 8'h00;
        end else if (k == 1) begin
            fc  = FC_WR_COILS;
            qt  = ($urandom_range(0, 9) != 0) ? 16'($urandom_range(1, 64))
                                              : 16'($urandom_range(1, MAX_COILS));
            cnt = 8'((qt + 7) / 8);
        end else begin
            fc  = FC_WR_REGS;
            qt  = ($urandom_range(0, 9) != 0) ? 16'($urandom_range(1, 8))
                                              : 16'($urandom_range(1, MAX_REGS));
            cnt = 8'(2 * qt);
        end
    endtask

    task automatic random_case();
        int r;
        int k;
        int flen;
        logic [7:0]  fc;
        logic [7:0]  cnt;
        logic [15:0] ad;
        logic [15:0] qt;
        r = $urandom_range(0, 99);
        if (r < 52) begin
            pick_good(fc, ad, qt, cnt);
            send_frame(fc, ad, qt, cnt, 1'b0, 0);
            if ($urandom_range(0, 3) == 0) put(8'($urandom_range(0, 255)), 1'b1);
        end else if (r < 60) begin
            pick_good(fc, ad, qt, cnt);
            send_frame(fc, ad, qt, cnt, 1'b1, 0);
            put(8'($urandom_range(0, 255)), 1'b1);
        end else if (r < 68) begin
            fc = $urandom_range(0, 1) ? FC_WR_COILS : FC_WR_REGS;
            ad = 16'($urandom_range(0, 16'hFFFF));
            k  = $urandom_range(0, 2);
            if (k == 0) begin
                qt  = 16'h0000;
                cnt = 8'($urandom_range(0, 4));
            end else if (k == 1) begin
                qt  = (fc == FC_WR_COILS) ? 16'($urandom_range(MAX_COILS + 1, 16'hFFFF))
                                          : 16'($urandom_range(MAX_REGS + 1, 16'hFFFF));
                cnt = 8'($urandom_range(0, 8));
            end else begin
                // Legal quantity, but a byte count that disagrees with it.
                qt  = (fc == FC_WR_COILS) ? 16'($urandom_range(1, 64))
                                          : 16'($urandom_range(1, 8));
                cnt = (fc == FC_WR_COILS) ? 8'((qt + 7) / 8) : 8'(2 * qt);
                cnt = cnt ^ (8'h01 << $urandom_range(0, 3));
            end
            send_frame(fc, ad, qt, cnt, 1'b0, 0);
            put(8'($urandom_range(0, 255)), 1'b1);
        end else if (r < 74) begin
            k = $urandom_range(0, 2);
            if (k == 0) fc = 8'h00;
            else if (k == 1) fc = 8'($urandom_range(FC_BASIC_LAST + 1, FC_WR_COILS - 1));
            else fc = 8'($urandom_range(FC_WR_REGS + 1, 255));
            send_frame(fc, 16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                       8'h00, 1'b0, 0);
            put(8'($urandom_range(0, 255)), 1'b1);
        end else if (r < 84) begin
            pick_good(fc, ad, qt, cnt);
            flen = (fc == FC_WR_COILS || fc == FC_WR_REGS) ? 32'(cnt) + 9 : 8;
            send_frame(fc, ad, qt, cnt, 1'b0, $urandom_range(1, flen - 1));
        end else if (r < 93) begin
            repeat ($urandom_range(1, 5)) put(8'($urandom_range(0, 255)), 1'b0);
            if ($urandom_range(0, 1)) put(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            put(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    task automatic random_items(input int n);
        int target;
        target = items_sent + n;
        while (items_sent < target) begin
            if ($urandom_range(0, 49) == 0) steady = !steady;
            random_case();
        end
        steady = 1'b0;
    endtask

    task automatic directed_cases();
        logic [7:0] bad_fc[5];
        bad_fc = '{8'h00, 8'h07, 8'h0E, 8'h11, 8'hFF};
        // Silence and stray bytes while hunting.
        put(8'h00, 1'b1);
        put(8'hFF, 1'b0);
        put(8'h00, 1'b0);
        // Good frames at the field extremes, back to back.
        send_frame(FC_BASIC_FIRST, 16'hFFFF, 16'hFFFF, 8'h00, 1'b0, 0);
        send_frame(FC_BASIC_LAST, 16'h0000, 16'h0000, 8'h00, 1'b0, 0);
        send_frame(8'h03, 16'h1234, 16'h0001, 8'h00, 1'b0, 0);
        send_frame(FC_WR_COILS, 16'h0013, 16'h0001, 8'd1, 1'b0, 0);
        send_frame(FC_WR_COILS, 16'h0000, MAX_COILS, 8'd246, 1'b0, 0);
        send_frame(FC_WR_REGS, 16'hABCD, 16'h0001, 8'd2, 1'b0, 0);
        send_frame(FC_WR_REGS, 16'h0001, MAX_REGS, 8'd246, 1'b0, 0);
        // A CRC error; the following address byte must still be dropped.
        send_frame(8'h04, 16'h0010, 16'h0002, 8'h00, 1'b1, 0);
        put(slave_addr, 1'b0);
        put(8'h00, 1'b1);
        // Illegal function codes on both sides of the legal ranges.
        foreach (bad_fc[i]) begin
            send_frame(bad_fc[i], 16'h0100, 16'h0002, 8'h00, 1'b0, 0);
            put(8'h00, 1'b1);
        end
        // Illegal quantities: zero, over the limit, byte count mismatch.
        // Over the limit the rest of the frame is dropped, so it is cut after the header.
        send_frame(FC_WR_COILS, 16'h0000, 16'h0000, 8'd0, 1'b0, 0);
        put(8'h00, 1'b1);
        send_frame(FC_WR_COILS, 16'h0000, MAX_COILS + 16'd1, 8'd247, 1'b0, 8);
        send_frame(FC_WR_COILS, 16'h0000, 16'd9, 8'd1, 1'b0, 0);
        put(8'h00, 1'b1);
        send_frame(FC_WR_REGS, 16'h0000, MAX_REGS + 16'd1, 8'd248, 1'b0, 8);
        send_frame(FC_WR_REGS, 16'h0000, 16'h0000, 8'd0, 1'b0, 0);
        put(8'h00, 1'b1);
        send_frame(FC_WR_REGS, 16'h0000, 16'd3, 8'd5, 1'b0, 0);
        put(8'h00, 1'b1);
        // Short frames: right after the address, mid header, inside the CRC and inside the payload.
        send_frame(8'h02, 16'h5555, 16'hAAAA, 8'h00, 1'b0, 1);
        send_frame(8'h02, 16'h5555, 16'hAAAA, 8'h00, 1'b0, 4);
        send_frame(8'h05, 16'h00FF, 16'hFF00, 8'h00, 1'b0, 7);
        send_frame(FC_WR_COILS, 16'h0020, 16'd16, 8'd2, 1'b0, 9);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 8'h00;
        in_ch.valid   = 1'b0;
        in_ch.rx_byte = 8'h00;
        in_ch.gap     = 1'b0;
        slave_addr    = SLAVE_ADDR_RST;
        steady        = 1'b0;
        hold_out      = 1'b0;
        items_sent    = 0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_cases();
        write_slave(8'h00);
        random_items(RANDOM_CHUNK);
        write_slave(8'hFF);
        random_items(RANDOM_CHUNK);
        write_slave(8'($urandom_range(0, 255)));
        random_items(RANDOM_CHUNK);

        // Results are held back while frames keep coming, so the input must stall.
        write_slave(SLAVE_ADDR_RST);
        hold_out = 1'b1;
        steady   = 1'b1;
        repeat (6) begin : hold_frames
            logic [7:0]  fc;
            logic [7:0]  cnt;
            logic [15:0] ad;
            logic [15:0] qt;
            pick_good(fc, ad, qt, cnt);
            send_frame(fc, ad, qt, cnt, 1'b0, 0);
        end
        steady = 1'b0;
        settle();
        random_items(RANDOM_CHUNK);

        settle();
        repeat (8) @(negedge i_clk);

        $display("tb: %0d input transfers, %0d results checked, %0d of them good frames",
                 in_count, checked, good_count);
        $display("tb: slave addresses 0x01, 0x00, 0xFF and a random one; one long result stall");
        if (pending != 0) $error("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/mbrtu_pkg.sv
sv/mbrtu_ifs.sv
sv/mbrtu_hdr_check.sv
sv/modbus_rtu_request_frame_checker_top.sv
sim/mbrtu_frame_checker.sv
sim/tb_modbus_rtu_request_frame_checker_top.sv
